[rtl/pss_pkg.sv]
// Shared constants, codes and control types of the positional sequence store.
`default_nettype none
package pss_pkg;

    localparam int DEPTH_DEF         = 256;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int LENGTH_W = 9;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD_WAIT,
        ST_SHIFT,
        ST_FINISH,
        ST_RESP
    } pss_state_t;

    typedef struct packed {
        logic cap_req;
        logic res_load;
        logic res_value;
        logic rd_pos;
        logic rd_last;
        logic wr_pos;
        logic wr_end;
        logic cnt_inc;
        logic cnt_dec;
        logic shift_init;
        logic shift_step;
    } pss_cmd_t;

    typedef struct packed {
        logic              err;
        logic [MODE_W-1:0] mode;
        logic              shift_busy;
    } pss_stat_t;

endpackage
`default_nettype wire

[rtl/pss_dp.sv]
// Datapath: element memory, length counter, request and result registers, shift pointers.
`default_nettype none
module pss_dp #(
    parameter int DEPTH         = pss_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = pss_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pss_pkg::pss_cmd_t             cmd,
    output pss_pkg::pss_stat_t                 stat,
    input  wire logic [pss_pkg::MODE_W-1:0]    req_mode,
    input  wire logic [pss_pkg::POS_W-1:0]     req_position,
    input  wire logic [pss_pkg::DATA_W-1:0]    req_value,
    output logic      [pss_pkg::DATA_W-1:0]    res_value,
    output logic      [pss_pkg::LENGTH_W-1:0]  res_length,
    output logic      [pss_pkg::STATUS_W-1:0]  res_status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > pss_pkg::POS_W) ? CW : pss_pkg::POS_W;

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

    logic [pss_pkg::MODE_W-1:0]   mode_reg;
    logic [pss_pkg::POS_W-1:0]    pos_reg;
    logic [ELEMENT_WIDTH-1:0]     data_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                remain_reg, remain_next;
    logic                         pend_reg, pend_next;
    logic [AW-1:0]                pend_addr_reg, pend_addr_next;
    logic [ELEMENT_WIDTH-1:0]     rd_data_reg;
    logic [pss_pkg::DATA_W-1:0]   value_reg;
    logic [pss_pkg::STATUS_W-1:0] status_reg;

    logic [CMPW-1:0]              pos_c, cnt_c;
    logic                         full;
    logic [pss_pkg::STATUS_W-1:0] chk_status;
    logic                         rd_en, wr_en;
    logic [AW-1:0]                rd_addr, wr_addr, pos_addr, last_addr;
    logic [ELEMENT_WIDTH-1:0]     wr_data;

    assign pos_c     = CMPW'(pos_reg);
    assign cnt_c     = CMPW'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign pos_addr  = AW'(pos_reg);
    assign last_addr = AW'(count_reg - CW'(1));

    always_comb begin
        chk_status = pss_pkg::STAT_OK;
        case (mode_reg) inside
            pss_pkg::MODE_APPEND: begin
                if (full) chk_status = pss_pkg::STAT_FULL;
            end
            pss_pkg::MODE_REMOVE: begin
                if (count_reg == '0) chk_status = pss_pkg::STAT_BAD;
            end
            pss_pkg::MODE_READ, pss_pkg::MODE_REPLACE, pss_pkg::MODE_DELETE: begin
                if (pos_c >= cnt_c) chk_status = pss_pkg::STAT_BAD;
            end
            pss_pkg::MODE_INSERT: begin
                if (full) begin
                    chk_status = pss_pkg::STAT_FULL;
                end else if (pos_c > cnt_c) begin
                    chk_status = pss_pkg::STAT_BAD;
                end
            end
            default: chk_status = pss_pkg::STAT_BAD;
        endcase
    end

    assign stat.err        = (chk_status != pss_pkg::STAT_OK);
    assign stat.mode       = mode_reg;
    assign stat.shift_busy = (remain_reg != '0) || pend_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        ptr_next       = ptr_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        if (cmd.shift_init) begin
            pend_next = 1'b0;
            if (mode_reg == pss_pkg::MODE_INSERT) begin
                ptr_next    = last_addr;
                remain_next = CW'(cnt_c - pos_c);
            end else begin
                ptr_next    = AW'(pos_c + CMPW'(1));
                remain_next = CW'(cnt_c - pos_c - CMPW'(1));
            end
        end else if (cmd.shift_step) begin
            if (remain_reg != '0) begin
                remain_next = remain_reg - CW'(1);
                pend_next   = 1'b1;
                if (mode_reg == pss_pkg::MODE_INSERT) begin
                    ptr_next       = ptr_reg - AW'(1);
                    pend_addr_next = ptr_reg + AW'(1);
                end else begin
                    ptr_next       = ptr_reg + AW'(1);
                    pend_addr_next = ptr_reg - AW'(1);
                end
            end else begin
                pend_next = 1'b0;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = ptr_reg;
        if (cmd.rd_pos) begin
            rd_addr = pos_addr;
        end else if (cmd.rd_last) begin
            rd_addr = last_addr;
        end else if (cmd.shift_step && (remain_reg != '0)) begin
            rd_addr = ptr_reg;
        end else begin
            rd_en = 1'b0;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = pos_addr;
        wr_data = data_reg;
        if (pend_reg) begin
            wr_addr = pend_addr_reg;
            wr_data = rd_data_reg;
        end else if (cmd.wr_pos) begin
            wr_addr = pos_addr;
        end else if (cmd.wr_end) begin
            wr_addr = AW'(count_reg);
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            remain_reg <= '0;
            pend_reg   <= 1'b0;
        end else begin
            count_reg  <= count_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        if (cmd.cap_req) begin
            mode_reg <= req_mode;
            pos_reg  <= req_position;
            data_reg <= ELEMENT_WIDTH'(req_value);
        end
        if (cmd.res_load) begin
            value_reg  <= '0;
            status_reg <= chk_status;
        end else if (cmd.res_value) begin
            value_reg <= pss_pkg::DATA_W'(rd_data_reg);
        end
    end

    assign res_value  = value_reg;
    assign res_length = pss_pkg::LENGTH_W'(count_reg);
    assign res_status = status_reg;

endmodule
`default_nettype wire

[rtl/pss_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`default_nettype none
module pss_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire pss_pkg::pss_stat_t stat,
    output pss_pkg::pss_cmd_t       cmd
);

    pss_pkg::pss_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pss_pkg::ST_IDLE: begin
                if (s_valid) state_next = pss_pkg::ST_EVAL;
            end
            pss_pkg::ST_EVAL: begin
                if (stat.err) begin
                    state_next = pss_pkg::ST_RESP;
                end else begin
                    unique case (stat.mode) inside
                        pss_pkg::MODE_READ, pss_pkg::MODE_REMOVE, pss_pkg::MODE_DELETE:
                            state_next = pss_pkg::ST_RD_WAIT;
                        pss_pkg::MODE_INSERT:
                            state_next = pss_pkg::ST_SHIFT;
                        default:
                            state_next = pss_pkg::ST_RESP;
                    endcase
                end
            end
            pss_pkg::ST_RD_WAIT: begin
                if (stat.mode == pss_pkg::MODE_DELETE) begin
                    state_next = pss_pkg::ST_SHIFT;
                end else begin
                    state_next = pss_pkg::ST_RESP;
                end
            end
            pss_pkg::ST_SHIFT: begin
                if (!stat.shift_busy) state_next = pss_pkg::ST_FINISH;
            end
            pss_pkg::ST_FINISH: state_next = pss_pkg::ST_RESP;
            pss_pkg::ST_RESP: begin
                if (m_ready) state_next = pss_pkg::ST_IDLE;
            end
            default: state_next = pss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            pss_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.cap_req = s_valid;
            end
            pss_pkg::ST_EVAL: begin
                cmd.res_load = 1'b1;
                if (!stat.err) begin
                    unique case (stat.mode) inside
                        pss_pkg::MODE_APPEND: begin
                            cmd.wr_end  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                        pss_pkg::MODE_REMOVE: begin
                            cmd.rd_last = 1'b1;
                            cmd.cnt_dec = 1'b1;
                        end
                        pss_pkg::MODE_READ, pss_pkg::MODE_DELETE: cmd.rd_pos = 1'b1;
                        pss_pkg::MODE_REPLACE: cmd.wr_pos = 1'b1;
                        pss_pkg::MODE_INSERT: cmd.shift_init = 1'b1;
                        default: cmd.res_load = 1'b1;
                    endcase
                end
            end
            pss_pkg::ST_RD_WAIT: begin
                cmd.res_value  = 1'b1;
                cmd.shift_init = (stat.mode == pss_pkg::MODE_DELETE);
            end
            pss_pkg::ST_SHIFT: cmd.shift_step = 1'b1;
            pss_pkg::ST_FINISH: begin
                if (stat.mode == pss_pkg::MODE_INSERT) begin
                    cmd.wr_pos  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end else begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            pss_pkg::ST_RESP: m_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/positional_sequence_store_core.sv]
// Top level of the positional sequence store: fixed-capacity ordered list of elements.
// Requests arrive on the s_ channel (mode, position, value_in) and each gives exactly
// one result on the m_ channel (value_out, length, status), both with valid/ready.
// One request is handled at a time; s_ready is high only while the block is idle.
// Result valid rises after the EVAL state for append, replace and any rejected
// request, and after the EVAL and RD_WAIT states for read and remove last.
// Insert and delete move the later elements one place per cycle through the single
// read and single write port of the element memory in the SHIFT state, then pass
// through FINISH before their result valid rises.
// The next request can be taken in the cycle after the result transfer.
// A full store, an empty store or a bad index is reported in status with no change.
// Reset clears the length and the controller; element memory contents are not
// cleared, and only written entries are ever read back.
// The result is held in output registers until its transfer; while the receiver
// stalls, no new request is taken.
`default_nettype none
module positional_sequence_store_core #(
    parameter int DEPTH         = pss_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = pss_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pss_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [pss_pkg::POS_W-1:0]     s_position,
    input  wire logic [pss_pkg::DATA_W-1:0]    s_value_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pss_pkg::DATA_W-1:0]    m_value_out,
    output logic      [pss_pkg::LENGTH_W-1:0]  m_length,
    output logic      [pss_pkg::STATUS_W-1:0]  m_status
);

    pss_pkg::pss_cmd_t  cmd;
    pss_pkg::pss_stat_t stat;

    pss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pss_dp #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .req_mode     (s_mode),
        .req_position (s_position),
        .req_value    (s_value_in),
        .res_value    (m_value_out),
        .res_length   (m_length),
        .res_status   (m_status)
    );

endmodule
`default_nettype wire

[rtl/pss_checker.sv]
// Port-level assertions for the positional sequence store, bound to the top level.
`default_nettype none
module pss_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [pss_pkg::DATA_W-1:0]    m_value_out,
    input wire logic [pss_pkg::LENGTH_W-1:0]  m_length,
    input wire logic [pss_pkg::STATUS_W-1:0]  m_status
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_length)
            && $stable(m_status))
        else $error("Result changed or dropped while stalled.");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pss_pkg::STAT_OK) |-> m_value_out == '0)
        else $error("Rejected request returned a nonzero value.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not idle after reset.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == pss_pkg::STAT_OK) || (m_status == pss_pkg::STAT_FULL)
            || (m_status == pss_pkg::STAT_BAD))
        else $error("Undefined status code.");

endmodule

bind positional_sequence_store_core pss_checker u_pss_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value_out (m_value_out),
    .m_length    (m_length),
    .m_status    (m_status)
);
`default_nettype wire
